[rtl/bfcd_pkg.sv]
// Shared types, codes and defaults of the banked flash command decoder.
package bfcd_pkg;

    localparam int OFFSET_W = 19;
    localparam int ADDR_W   = 20;
    localparam int DATA_W   = 8;
    localparam int BANK_W   = 2;

    localparam int SECTOR_BYTES_DEF       = 4096;
    localparam int FLASH_ADDRESS_BITS_DEF = 20;

    localparam logic OP_WINDOW = 1'b0;
    localparam logic OP_BANK   = 1'b1;

    typedef enum logic [1:0] {
        ACT_PROGRAM = 2'd0,
        ACT_ERASE   = 2'd1,
        ACT_RESET   = 2'd2,
        ACT_BANK    = 2'd3
    } action_t;

    localparam logic [BANK_W-1:0] BANK_BOOT = 2'd0;
    localparam logic [BANK_W-1:0] BANK_SLOT = 2'd1;
    localparam logic [BANK_W-1:0] BANK_MAIN = 2'd2;
    localparam logic [BANK_W-1:0] BANK_ROM  = 2'd3;

    localparam logic [ADDR_W-1:0] BASE_BOOT = 20'h0C0000;
    localparam logic [ADDR_W-1:0] BASE_SLOT = 20'h080000;

    localparam logic [OFFSET_W-1:0] CMD_ADDR_A = 19'h05555;
    localparam logic [OFFSET_W-1:0] CMD_ADDR_B = 19'h02AAA;

    localparam logic [DATA_W-1:0] CMD_UNLOCK1 = 8'hAA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK2 = 8'h55;
    localparam logic [DATA_W-1:0] CMD_PROGRAM = 8'hA0;
    localparam logic [DATA_W-1:0] CMD_ERASE   = 8'h80;
    localparam logic [DATA_W-1:0] CMD_SECTOR  = 8'h30;
    localparam logic [DATA_W-1:0] CMD_RESET   = 8'hF0;

    typedef struct packed {
        logic                operation;
        logic [OFFSET_W-1:0] window_offset;
        logic [DATA_W-1:0]   write_data;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] flash_address;
        logic [DATA_W-1:0] program_data;
        logic              to_onboard_rom;
    } act_t;

    typedef struct packed {
        logic valid;
        act_t act;
    } res_t;

endpackage

[rtl/bfcd_if.sv]
// Valid/ready channel interfaces for bus writes and flash actions.
interface bfcd_cmd_if
    import bfcd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [OFFSET_W-1:0] window_offset;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, output operation, output window_offset,
                    output write_data, input ready);
    modport sink   (input valid, input operation, input window_offset,
                    input write_data, output ready);
endinterface

interface bfcd_act_if
    import bfcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [ADDR_W-1:0] flash_address;
    logic [DATA_W-1:0] program_data;
    logic              to_onboard_rom;

    modport source (output valid, output action, output flash_address,
                    output program_data, output to_onboard_rom, input ready);
    modport sink   (input valid, input action, input flash_address,
                    input program_data, input to_onboard_rom, output ready);
endinterface

[rtl/bfcd_seq_fsm.sv]
// Unlock-command state machine, bank register and address translation.
module bfcd_seq_fsm
    import bfcd_pkg::*;
#(
    parameter int SECTOR_BYTES       = SECTOR_BYTES_DEF,
    parameter int FLASH_ADDRESS_BITS = FLASH_ADDRESS_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  cmd_t cmd,
    output res_t res
);

    localparam int MASK_BITS =
        (FLASH_ADDRESS_BITS < ADDR_W) ? FLASH_ADDRESS_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'((64'd1 << MASK_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] SECTOR_MASK = ~ADDR_W'(SECTOR_BYTES - 1);

    typedef enum logic [6:0] {
        ST_IDLE          = 7'b0000001,
        ST_UNLOCK1       = 7'b0000010,
        ST_UNLOCK2       = 7'b0000100,
        ST_PROGRAM       = 7'b0001000,
        ST_ERASE_SETUP   = 7'b0010000,
        ST_ERASE_UNLOCK1 = 7'b0100000,
        ST_ERASE_UNLOCK2 = 7'b1000000
    } stage_t;

    stage_t              stage_reg, stage_next;
    logic [BANK_W-1:0]   bank_reg, bank_next;
    logic [BANK_W-1:0]   new_bank;
    logic [OFFSET_W-1:0] inbank;
    logic [ADDR_W-1:0]   phys;
    logic [ADDR_W-1:0]   new_base;
    logic                at_a, at_b;
    logic [DATA_W-1:0]   wdata;

    function automatic logic [ADDR_W-1:0] bank_base(input logic [BANK_W-1:0] bank);
        logic [ADDR_W-1:0] base;
        unique case (bank)
            BANK_BOOT: base = BASE_BOOT;
            BANK_SLOT: base = BASE_SLOT;
            default:   base = '0;
        endcase
        return base;
    endfunction

    assign wdata    = cmd.write_data;
    assign new_bank = wdata[BANK_W-1:0];
    assign inbank   = ((bank_reg == BANK_BOOT) || (bank_reg == BANK_SLOT))
                    ? {1'b0, cmd.window_offset[OFFSET_W-2:0]}
                    : cmd.window_offset;
    assign phys     = (bank_base(bank_reg) + {1'b0, inbank}) & ADDR_MASK;
    assign new_base = bank_base(new_bank) & ADDR_MASK;
    assign at_a     = (inbank == CMD_ADDR_A);
    assign at_b     = (inbank == CMD_ADDR_B);

    always_comb
    begin
        stage_next                 = stage_reg;
        bank_next                  = bank_reg;
        res                        = '0;
        res.act.flash_address      = phys;
        res.act.program_data       = wdata;
        res.act.to_onboard_rom     = (bank_reg == BANK_ROM);
        if (fire)
        begin
            if (cmd.operation == OP_BANK)
            begin
                bank_next                  = new_bank;
                res.valid                  = 1'b1;
                res.act.action             = ACT_BANK;
                res.act.flash_address      = new_base;
                res.act.program_data       = {{(DATA_W-BANK_W){1'b0}}, new_bank};
                res.act.to_onboard_rom     = (new_bank == BANK_ROM);
            end
            else if (stage_reg == ST_PROGRAM)
            begin
                stage_next     = ST_IDLE;
                res.valid      = 1'b1;
                res.act.action = ACT_PROGRAM;
            end
            else if (wdata == CMD_RESET)
            begin
                stage_next     = ST_IDLE;
                res.valid      = 1'b1;
                res.act.action = ACT_RESET;
            end
            else
            begin
                stage_next = ST_IDLE;
                unique case (stage_reg)
                    ST_IDLE:
                        if (at_a && wdata == CMD_UNLOCK1) stage_next = ST_UNLOCK1;
                    ST_UNLOCK1:
                        if (at_b && wdata == CMD_UNLOCK2) stage_next = ST_UNLOCK2;
                    ST_UNLOCK2:
                        if (at_a && wdata == CMD_PROGRAM)    stage_next = ST_PROGRAM;
                        else if (at_a && wdata == CMD_ERASE) stage_next = ST_ERASE_SETUP;
                    ST_ERASE_SETUP:
                        if (at_a && wdata == CMD_UNLOCK1) stage_next = ST_ERASE_UNLOCK1;
                    ST_ERASE_UNLOCK1:
                        if (at_b && wdata == CMD_UNLOCK2) stage_next = ST_ERASE_UNLOCK2;
                    ST_ERASE_UNLOCK2:
                        if (wdata == CMD_SECTOR)
                        begin
                            res.valid             = 1'b1;
                            res.act.action        = ACT_ERASE;
                            res.act.flash_address = phys & SECTOR_MASK;
                        end
                    default:
                        stage_next = ST_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_IDLE;
            bank_reg  <= BANK_BOOT;
        end
        else
        begin
            stage_reg <= stage_next;
            bank_reg  <= bank_next;
        end
    end

    a_bank_keeps_stage: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd.operation == OP_BANK |=> stage_reg == $past(stage_reg))
        else $error("bank write changed sequence stage");

    a_program_ends: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd.operation == OP_WINDOW && stage_reg == ST_PROGRAM
        |=> stage_reg == ST_IDLE)
        else $error("program slot did not return to idle");

    a_erase_from_unlock: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.act.action == ACT_ERASE |-> stage_reg == ST_ERASE_UNLOCK2)
        else $error("erase issued outside the erase unlock stage");

    a_erase_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.act.action == ACT_ERASE
        |-> (res.act.flash_address & ~SECTOR_MASK) == '0)
        else $error("erase address not sector aligned");

    a_bank_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && cmd.operation == OP_BANK) |=> bank_reg == $past(bank_reg))
        else $error("bank changed without a bank write");

endmodule

[rtl/banked_flash_command_decoder.sv]
// Top level of the banked flash command decoder.
// The action is shown from the output register in the cycle after the input transfer.
// Throughput: one bus write per cycle; the single output register sets it and takes
// a new write only while it is empty or being drained in the same cycle.
// Reset: sequence stage to idle, bank to the bootloader bank, output register empty.
// SECTOR_BYTES must be a power of two.
module banked_flash_command_decoder
    import bfcd_pkg::*;
#(
    parameter int SECTOR_BYTES       = SECTOR_BYTES_DEF,
    parameter int FLASH_ADDRESS_BITS = FLASH_ADDRESS_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    bfcd_cmd_if.sink  cmd,
    bfcd_act_if.source act
);

    cmd_t cmd_word;
    res_t res;
    logic fire;
    logic out_valid_reg, out_valid_next;
    act_t out_reg;

    assign cmd.ready = !out_valid_reg || act.ready;
    assign fire      = cmd.valid && cmd.ready;

    assign cmd_word.operation     = cmd.operation;
    assign cmd_word.window_offset = cmd.window_offset;
    assign cmd_word.write_data    = cmd.write_data;

    bfcd_seq_fsm #(
        .SECTOR_BYTES       (SECTOR_BYTES),
        .FLASH_ADDRESS_BITS (FLASH_ADDRESS_BITS)
    ) u_seq_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cmd   (cmd_word),
        .res   (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (act.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire && res.valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
        begin
            out_reg <= res.act;
        end
    end

    assign act.valid          = out_valid_reg;
    assign act.action         = out_reg.action;
    assign act.flash_address  = out_reg.flash_address;
    assign act.program_data   = out_reg.program_data;
    assign act.to_onboard_rom = out_reg.to_onboard_rom;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !act.ready |-> !cmd.ready)
        else $error("input taken while a result is stalled");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.valid |=> out_valid_reg)
        else $error("result transfer lost");

    a_idle_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && res.valid) && act.ready |=> !out_valid_reg)
        else $error("result repeated after transfer");

endmodule

[tb/tb_top.sv]
// Testbench for the banked flash command decoder: directed table, random write sequences, scoreboard.
`timescale 1ns / 100ps

module tb_top
    import bfcd_pkg::*;
();

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_WRITES  = 800;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT        = 100;
    localparam int DRAIN_AT       = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int STALL_LIMIT    = 2000;
    localparam int DIRECTED_COUNT = 26;

    localparam logic [OFFSET_W-1:0] WRAP_MASK   = 19'h3FFFF;
    localparam logic [ADDR_W-1:0]   ADDR_MASK   =
        ADDR_W'((64'd1 << FLASH_ADDRESS_BITS_DEF) - 64'd1);
    localparam logic [ADDR_W-1:0]   SECTOR_MASK = ~ADDR_W'(SECTOR_BYTES_DEF - 1);

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_UNLOCK1,
        SEQ_UNLOCK2,
        SEQ_PROGRAM,
        SEQ_ERASE_SETUP,
        SEQ_ERASE_UNLOCK1,
        SEQ_ERASE_UNLOCK2
    } seq_stage_t;

    typedef struct packed {
        cmd_t w;
        logic fixed;
        logic fires;
        act_t want;
    } write_row_t;

    logic clk;
    logic rst_n;

    bfcd_cmd_if cmd_ch ();
    bfcd_act_if act_ch ();

    banked_flash_command_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .act   (act_ch)
    );

    seq_stage_t seq_stage = SEQ_IDLE;
    logic [BANK_W-1:0] cur_bank = BANK_BOOT;
    act_t pending_actions[$];
    write_row_t directed_writes [DIRECTED_COUNT];
    write_row_t random_writes[$];
    int mismatches = 0;
    int burst_left = 0;
    bit hold_off_req = 0;
    bit drain_before_next = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [ADDR_W-1:0] bank_base(logic [BANK_W-1:0] bank);
        case (bank)
            BANK_BOOT: return BASE_BOOT;
            BANK_SLOT: return BASE_SLOT;
            default:   return '0;
        endcase
    endfunction

    function automatic act_t make_action(action_t a, logic [ADDR_W-1:0] addr,
                                         logic [DATA_W-1:0] pd);
        act_t r;
        r.action         = a;
        r.flash_address  = addr;
        r.program_data   = pd;
        r.to_onboard_rom = (cur_bank == BANK_ROM);
        return r;
    endfunction

    function automatic void decode_bus_write(input cmd_t w, output bit fires,
                                             output act_t out);
        logic [OFFSET_W-1:0] inbank;
        logic [ADDR_W-1:0]   phys;
        seq_stage_t          stage;
        fires = 1'b0;
        out   = '0;
        if (w.operation == OP_BANK)
        begin
            cur_bank = w.write_data[BANK_W-1:0];
            fires    = 1'b1;
            out      = make_action(ACT_BANK, bank_base(cur_bank) & ADDR_MASK,
                                   DATA_W'(cur_bank));
            return;
        end
        inbank = (cur_bank == BANK_BOOT || cur_bank == BANK_SLOT) ?
                 (w.window_offset & WRAP_MASK) : w.window_offset;
        phys   = (bank_base(cur_bank) + ADDR_W'(inbank)) & ADDR_MASK;
        stage     = seq_stage;
        seq_stage = SEQ_IDLE;
        if (stage == SEQ_PROGRAM)
        begin
            fires = 1'b1;
            out   = make_action(ACT_PROGRAM, phys, w.write_data);
        end
        else if (w.write_data == CMD_RESET)
        begin
            fires = 1'b1;
            out   = make_action(ACT_RESET, phys, CMD_RESET);
        end
        else
        begin
            case (stage)
                SEQ_IDLE:
                    if (inbank == CMD_ADDR_A && w.write_data == CMD_UNLOCK1)
                        seq_stage = SEQ_UNLOCK1;
                SEQ_UNLOCK1:
                    if (inbank == CMD_ADDR_B && w.write_data == CMD_UNLOCK2)
                        seq_stage = SEQ_UNLOCK2;
                SEQ_UNLOCK2:
                    if (inbank == CMD_ADDR_A && w.write_data == CMD_PROGRAM)
                        seq_stage = SEQ_PROGRAM;
                    else if (inbank == CMD_ADDR_A && w.write_data == CMD_ERASE)
                        seq_stage = SEQ_ERASE_SETUP;
                SEQ_ERASE_SETUP:
                    if (inbank == CMD_ADDR_A && w.write_data == CMD_UNLOCK1)
                        seq_stage = SEQ_ERASE_UNLOCK1;
                SEQ_ERASE_UNLOCK1:
                    if (inbank == CMD_ADDR_B && w.write_data == CMD_UNLOCK2)
                        seq_stage = SEQ_ERASE_UNLOCK2;
                SEQ_ERASE_UNLOCK2:
                    if (w.write_data == CMD_SECTOR)
                    begin
                        fires = 1'b1;
                        out   = make_action(ACT_ERASE, phys & SECTOR_MASK, CMD_SECTOR);
                    end
                default: ;
            endcase
        end
    endfunction

    function automatic write_row_t wr(logic op, logic [OFFSET_W-1:0] off,
                                      logic [DATA_W-1:0] d);
        write_row_t r;
        r = '0;
        r.w.operation     = op;
        r.w.window_offset = off;
        r.w.write_data    = d;
        return r;
    endfunction

    function automatic write_row_t wr_fixed(logic op, logic [OFFSET_W-1:0] off,
                                            logic [DATA_W-1:0] d, action_t a,
                                            logic [ADDR_W-1:0] addr,
                                            logic [DATA_W-1:0] pd, logic rom);
        write_row_t r;
        r = wr(op, off, d);
        r.fixed                = 1'b1;
        r.fires                = 1'b1;
        r.want.action          = a;
        r.want.flash_address   = addr;
        r.want.program_data    = pd;
        r.want.to_onboard_rom  = rom;
        return r;
    endfunction

    function automatic logic [OFFSET_W-1:0] alias_of(logic [OFFSET_W-1:0] a);
        if ($urandom_range(4) == 0)
            return {1'($urandom_range(1)), a[OFFSET_W-2:0]};
        return a;
    endfunction

    function automatic logic [DATA_W-1:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return CMD_UNLOCK1;
            1:       return CMD_UNLOCK2;
            2:       return CMD_PROGRAM;
            3:       return CMD_ERASE;
            4:       return CMD_SECTOR;
            5:       return CMD_RESET;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] any_offset();
        return OFFSET_W'($urandom);
    endfunction

    function automatic void build_command_sequence(ref write_row_t rows[$], input bit erase);
        rows.push_back(wr(OP_WINDOW, alias_of(CMD_ADDR_A), CMD_UNLOCK1));
        if ($urandom_range(7) == 0)
            rows.push_back(wr(OP_BANK, any_offset(), DATA_W'($urandom)));
        rows.push_back(wr(OP_WINDOW, alias_of(CMD_ADDR_B), CMD_UNLOCK2));
        if (!erase)
        begin
            rows.push_back(wr(OP_WINDOW, alias_of(CMD_ADDR_A), CMD_PROGRAM));
            rows.push_back(wr(OP_WINDOW, any_offset(), pick_byte()));
        end
        else
        begin
            rows.push_back(wr(OP_WINDOW, alias_of(CMD_ADDR_A), CMD_ERASE));
            rows.push_back(wr(OP_WINDOW, alias_of(CMD_ADDR_A), CMD_UNLOCK1));
            rows.push_back(wr(OP_WINDOW, alias_of(CMD_ADDR_B), CMD_UNLOCK2));
            rows.push_back(wr(OP_WINDOW, any_offset(), CMD_SECTOR));
        end
    endfunction

    function automatic void build_random_writes();
        write_row_t seq_rows[$];
        write_row_t bad;
        int kind;
        int keep;
        while (random_writes.size() < RANDOM_WRITES)
        begin
            seq_rows.delete();
            kind = $urandom_range(0, 15);
            if (kind <= 4)
                build_command_sequence(seq_rows, 1'b0);
            else if (kind <= 8)
                build_command_sequence(seq_rows, 1'b1);
            else if (kind <= 10)
                seq_rows.push_back(wr(OP_BANK, any_offset(), DATA_W'($urandom)));
            else if (kind == 11)
                seq_rows.push_back(wr(OP_WINDOW, any_offset(), CMD_RESET));
            else if (kind <= 13)
            begin
                build_command_sequence(seq_rows, kind[0]);
                keep = $urandom_range(1, seq_rows.size() - 1);
                bad  = seq_rows[keep];
                while (seq_rows.size() > keep)
                    void'(seq_rows.pop_back());
                if ($urandom_range(1) == 0)
                    bad.w.write_data = DATA_W'($urandom);
                else
                    bad.w.window_offset = any_offset();
                seq_rows.push_back(bad);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    seq_rows.push_back(wr(OP_WINDOW, any_offset(), pick_byte()));
            end
            foreach (seq_rows[i])
                random_writes.push_back(seq_rows[i]);
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic record_write(write_row_t r);
        bit   fires;
        act_t want;
        decode_bus_write(r.w, fires, want);
        if (r.fixed)
        begin
            fires = r.fires;
            want  = r.want;
        end
        if (fires)
            pending_actions.push_back(want);
    endtask

    task automatic send_write(write_row_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (drain_before_next && gap == 0)
                gap = 1;
            if (gap > 0 || drain_before_next)
            begin
                cmd_ch.valid <= 1'b0;
                if (drain_before_next)
                begin
                    drain_before_next = 1'b0;
                    while (pending_actions.size() != 0)
                        @(posedge clk);
                end
                repeat (gap)
                    @(posedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.operation     <= r.w.operation;
        cmd_ch.window_offset <= r.w.window_offset;
        cmd_ch.write_data    <= r.w.write_data;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        record_write(r);
        burst_left--;
    endtask

    always @(posedge clk)
    begin
        act_t want;
        if (rst_n && act_ch.valid && act_ch.ready)
        begin
            if (pending_actions.size() == 0)
                report_mismatch($sformatf("unexpected action %0d addr %h data %h",
                                          act_ch.action, act_ch.flash_address,
                                          act_ch.program_data));
            else
            begin
                want = pending_actions.pop_front();
                if (act_ch.action !== want.action)
                    report_mismatch($sformatf("action %0d, want %0d",
                                              act_ch.action, want.action));
                if (act_ch.flash_address !== want.flash_address)
                    report_mismatch($sformatf("flash_address %h, want %h",
                                              act_ch.flash_address, want.flash_address));
                if (act_ch.program_data !== want.program_data)
                    report_mismatch($sformatf("program_data %h, want %h",
                                              act_ch.program_data, want.program_data));
                if (act_ch.to_onboard_rom !== want.to_onboard_rom)
                    report_mismatch($sformatf("to_onboard_rom %b, want %b",
                                              act_ch.to_onboard_rom, want.to_onboard_rom));
            end
        end
    end

    initial
    begin
        int  mode;
        int  span;
        int  hold_left;
        bit  rdy;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            for (int i = 0; i < span; i++)
            begin
                if (hold_off_req && !held)
                begin
                    held      = 1'b1;
                    hold_left = LONG_HOLD;
                end
                if (hold_left > 0)
                begin
                    rdy = 1'b0;
                    hold_left--;
                end
                else
                begin
                    case (mode)
                        0:       rdy = 1'b1;
                        1:       rdy = 1'($urandom_range(1));
                        2:       rdy = (i % 8) >= 3;
                        default: rdy = ($urandom_range(7) == 0);
                    endcase
                end
                act_ch.ready <= rdy;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (act_ch.valid && act_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n                <= 1'b0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.operation     <= OP_WINDOW;
        cmd_ch.window_offset <= '0;
        cmd_ch.write_data    <= '0;

        directed_writes = '{
            wr_fixed(OP_WINDOW, 19'h00000, CMD_RESET, ACT_RESET, 20'hC0000, CMD_RESET, 1'b0),
            wr_fixed(OP_WINDOW, 19'h7FFFF, CMD_RESET, ACT_RESET, 20'hFFFFF, CMD_RESET, 1'b0),
            wr(OP_WINDOW, 19'h45555, CMD_UNLOCK1),
            wr(OP_WINDOW, 19'h42AAA, CMD_UNLOCK2),
            wr(OP_WINDOW, CMD_ADDR_A, CMD_PROGRAM),
            wr(OP_WINDOW, 19'h12345, CMD_RESET),
            wr(OP_WINDOW, CMD_ADDR_A, CMD_UNLOCK1),
            wr(OP_WINDOW, CMD_ADDR_B, CMD_UNLOCK2),
            wr(OP_WINDOW, CMD_ADDR_A, CMD_ERASE),
            wr(OP_WINDOW, CMD_ADDR_A, CMD_UNLOCK1),
            wr(OP_WINDOW, CMD_ADDR_B, CMD_UNLOCK2),
            wr_fixed(OP_WINDOW, 19'h7FFFF, CMD_SECTOR, ACT_ERASE, 20'hFF000, CMD_SECTOR, 1'b0),
            wr(OP_WINDOW, CMD_ADDR_A, CMD_UNLOCK1),
            wr(OP_WINDOW, CMD_ADDR_B, 8'h00),
            wr(OP_WINDOW, CMD_ADDR_B, CMD_UNLOCK2),
            wr(OP_WINDOW, CMD_ADDR_A, CMD_UNLOCK1),
            wr(OP_WINDOW, CMD_ADDR_B, CMD_RESET),
            wr_fixed(OP_BANK, 19'h7FFFF, 8'hFF, ACT_BANK, 20'h00000, 8'h03, 1'b1),
            wr_fixed(OP_WINDOW, 19'h7FFFF, CMD_RESET, ACT_RESET, 20'h7FFFF, CMD_RESET, 1'b1),
            wr(OP_WINDOW, CMD_ADDR_A, CMD_UNLOCK1),
            wr_fixed(OP_BANK, 19'h00000, 8'h01, ACT_BANK, 20'h80000, 8'h01, 1'b0),
            wr(OP_WINDOW, CMD_ADDR_B, CMD_UNLOCK2),
            wr_fixed(OP_BANK, 19'h2AAAA, 8'h06, ACT_BANK, 20'h00000, 8'h02, 1'b0),
            wr(OP_WINDOW, CMD_ADDR_A, CMD_PROGRAM),
            wr(OP_WINDOW, 19'h7FFFF, 8'h00),
            wr_fixed(OP_BANK, 19'h55555, 8'h00, ACT_BANK, 20'hC0000, 8'h00, 1'b0)
        };
        build_random_writes();

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_writes[i])
            send_write(directed_writes[i]);
        for (int i = 0; i < random_writes.size(); i++)
        begin
            if (i == HOLD_AT)
                hold_off_req = 1'b1;
            if (i == DRAIN_AT)
            begin
                drain_before_next = 1'b1;
                burst_left        = 0;
            end
            send_write(random_writes[i]);
        end
        cmd_ch.valid <= 1'b0;

        while (pending_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
